// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the glob matcher checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held
`define GWM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset
`define GWM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/gwm_pkg.sv =====
// ----------------------------------------------------------------------------
// gwm_pkg
// Types, codes and helper functions for the glob wildcard matcher.
// ----------------------------------------------------------------------------
package gwm_pkg;

    // Default size of the element store
    localparam int GWM_MAX_ELEMENTS = 32;

    // Beat function codes
    typedef enum logic [1:0] {
        FUNC_APPEND = 2'd0,
        FUNC_MEMBER = 2'd1,
        FUNC_BYTE   = 2'd2,
        FUNC_END    = 2'd3
    } t_func;

    // Element kinds; unknown codes behave as literals
    localparam logic [2:0] KIND_LITERAL = 3'd0;
    localparam logic [2:0] KIND_ANY_ONE = 3'd1;
    localparam logic [2:0] KIND_ANY_RUN = 3'd2;
    localparam logic [2:0] KIND_SET     = 3'd3;
    localparam logic [2:0] KIND_NOT_SET = 3'd4;

    // Input beat
    typedef struct packed {
        t_func      func;
        logic [2:0] elem_kind;
        logic [7:0] symbol;
        logic       restart;
        logic       last;
    } t_in_beat;

    // Result beat
    typedef struct packed {
        logic matched;
        logic overflow;
    } t_out_beat;

    // Per-cell write control
    typedef struct packed {
        logic       load;   // append element into this cell
        logic       clear;  // new pattern starts, drop this cell's element
        logic       add;    // add a set member to this cell
        logic [2:0] kind;
        logic [7:0] sym;
    } t_cell_ctl;

    // Subject byte broadcast to every cell
    typedef struct packed {
        logic [7:0] sym;
        logic [7:0] sym_alt;  // other ASCII case
        logic [7:0] sym_low;  // lower ASCII case
        logic       fold;
    } t_subj;

    function automatic logic [7:0] lower_ascii(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A) r = c + 8'h20;
        return r;
    endfunction

    function automatic logic [7:0] other_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A) r = c + 8'h20;
        else if (c >= 8'h61 && c <= 8'h7A) r = c - 8'h20;
        return r;
    endfunction

endpackage

// ===== src/glob_wildcard_matcher.sv =====
// ----------------------------------------------------------------------------
// glob_wildcard_matcher
// Glob matcher (literal, ?, *, sets) over a row of element cells that track
// every live pattern position in parallel.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                   | payload
//  in      | sink      | i_in_valid / o_in_stall     | i_in_data  (t_in_beat)
//  out     | source    | o_out_valid / i_out_stall   | o_out_data (t_out_beat)
//  cfg     | sink      | i_cfg_valid / o_cfg_ready   | i_cfg_data (case_fold)
//
// One beat per cycle, every function, while o_in_stall is low. The result of the
// beat that ends a subject is registered in the output register or the skid slot.
// The per-byte critical path is the mask lookup plus the star-closure chain
// running through all MAX_ELEMENTS cells.
// Reset (synchronous) clears the pattern and fold; no clearing pass needed.
// A skid register behind the output lets input continue during an output
// stall; o_in_stall rises only when both result slots are full.
// ----------------------------------------------------------------------------
module glob_wildcard_matcher import gwm_pkg::*; #(
    parameter int MAX_ELEMENTS = GWM_MAX_ELEMENTS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_beat  i_in_data,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_beat o_out_data,
    input  logic      i_out_stall,
    input  logic      i_cfg_valid,
    input  logic      i_cfg_data,
    output logic      o_cfg_ready
);

    localparam int LW = $clog2(MAX_ELEMENTS + 1);
    localparam int NP = MAX_ELEMENTS + 1;

    // Configuration
    logic r_case_fold;

    // Pattern bookkeeping
    logic [LW-1:0] r_len, n_len;
    logic          r_too_long, n_too_long;
    logic [NP-1:0] r_start, n_start;

    // Live positions
    logic          r_at_start, n_at_start;
    logic [NP-1:0] r_alive;
    logic [NP-1:0] cur;

    // Result slots
    logic      r_out_valid, r_skid_valid;
    t_out_beat r_out, r_skid;

    logic          in_acc, do_append, do_member, do_byte, do_end, produce;
    logic [LW-1:0] base_len, add_idx;
    logic          base_tl, app_ok;
    logic [NP-1:0] base_start;
    logic          hit;
    t_out_beat     res;
    t_subj         subj;
    logic          out_free;

    logic [NP-1:0] adv, carry, closed;

    assign in_acc    = i_in_valid & ~o_in_stall;
    assign do_append = in_acc & (i_in_data.func == FUNC_APPEND);
    assign do_member = in_acc & (i_in_data.func == FUNC_MEMBER);
    assign do_byte   = in_acc & (i_in_data.func == FUNC_BYTE);
    assign do_end    = in_acc & (i_in_data.func == FUNC_END);
    assign produce   = do_end | (do_byte & i_in_data.last);

    // Config write
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_case_fold <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_case_fold <= i_cfg_data;
        end
    end

    // Append / member bookkeeping
    assign base_len   = i_in_data.restart ? '0 : r_len;
    assign base_tl    = i_in_data.restart ? 1'b0 : r_too_long;
    assign base_start = i_in_data.restart ? NP'(1) : r_start;
    assign app_ok     = do_append & (base_len != LW'(MAX_ELEMENTS));
    assign add_idx    = r_len - LW'(1);

    always_comb begin
        n_len      = r_len;
        n_too_long = r_too_long;
        n_start    = r_start;
        if (do_append) begin
            n_too_long = base_tl | ~app_ok;
            n_len      = app_ok ? base_len + LW'(1) : base_len;
            n_start    = base_start;
            for (int j = 1; j < NP; j++) begin
                if (app_ok && base_len == LW'(j - 1) && base_start[j-1] &&
                    i_in_data.elem_kind == KIND_ANY_RUN) begin
                    n_start[j] = 1'b1;
                end
            end
        end
    end

    // Start-position flag: pattern edits and subject ends return to start
    always_comb begin
        n_at_start = r_at_start;
        if (do_append || do_member || do_end) n_at_start = 1'b1;
        else if (do_byte)                     n_at_start = i_in_data.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len      <= '0;
            r_too_long <= 1'b0;
            r_start    <= NP'(1);
            r_at_start <= 1'b1;
        end else begin
            r_len      <= n_len;
            r_too_long <= n_too_long;
            r_start    <= n_start;
            r_at_start <= n_at_start;
        end
    end

    // Live vector after a byte (closed under stars)
    always_ff @(posedge i_clk) begin
        if (do_byte) r_alive <= closed;
    end

    assign cur = r_at_start ? r_start : r_alive;

    // Subject byte broadcast
    assign subj.sym     = i_in_data.symbol;
    assign subj.sym_alt = other_case(i_in_data.symbol);
    assign subj.sym_low = lower_ascii(i_in_data.symbol);
    assign subj.fold    = r_case_fold;

    // Cell row
    assign adv[0]   = 1'b0;
    assign carry[0] = 1'b0;

    for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
        t_cell_ctl ctl;
        assign ctl.load  = app_ok & (base_len == LW'(i));
        assign ctl.clear = do_append & i_in_data.restart;
        assign ctl.add   = do_member & (r_len != '0) & ~r_too_long & (add_idx == LW'(i));
        assign ctl.kind  = i_in_data.elem_kind;
        assign ctl.sym   = i_in_data.symbol;

        gwm_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (ctl),
            .i_subj   (subj),
            .i_cur    (cur[i]),
            .i_adv    (adv[i]),
            .i_carry  (carry[i]),
            .o_adv    (adv[i+1]),
            .o_carry  (carry[i+1]),
            .o_closed (closed[i])
        );
    end

    assign closed[MAX_ELEMENTS] = adv[MAX_ELEMENTS] | carry[MAX_ELEMENTS];

    // End-of-subject verdict
    assign hit          = do_end ? r_start[r_len] : closed[r_len];
    assign res.matched  = hit & ~r_too_long;
    assign res.overflow = r_too_long;

    // Output register with skid slot
    assign out_free   = ~r_out_valid | ~i_out_stall;
    assign o_in_stall = r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= produce;
            end else begin
                r_out_valid  <= produce;
            end
        end else if (produce) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
                if (produce) r_skid <= res;
            end else if (produce) begin
                r_out <= res;
            end
        end else if (produce) begin
            r_skid <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== src/gwm_cell.sv =====
// ----------------------------------------------------------------------------
// gwm_cell
// One pattern element: holds kind, byte and set mask, matches the subject
// byte and passes advance and star-closure bits to the next cell.
// ----------------------------------------------------------------------------
module gwm_cell import gwm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_subj     i_subj,
    input  logic      i_cur,    // this position alive before the byte
    input  logic      i_adv,    // left neighbour advanced into this position
    input  logic      i_carry,  // closure carried over a star on the left
    output logic      o_adv,
    output logic      o_carry,
    output logic      o_closed
);

    logic         r_used;
    logic [2:0]   r_kind;
    logic [7:0]   r_byte;
    logic [255:0] r_mask;
    logic         n_used;

    logic is_star;
    logic live;
    logic set_hit;
    logic ok;

    // Element present flag
    assign n_used = i_ctl.load | (r_used & ~i_ctl.clear);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
        end else begin
            r_used <= n_used;
        end
    end

    // Element payload and set mask
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_kind <= i_ctl.kind;
            r_byte <= i_ctl.sym;
            r_mask <= '0;
        end else if (i_ctl.add) begin
            r_mask[i_ctl.sym] <= 1'b1;
        end
    end

    // Byte match
    assign set_hit = r_mask[i_subj.sym] | (i_subj.fold & r_mask[i_subj.sym_alt]);

    always_comb begin
        case (r_kind)
            KIND_ANY_ONE: ok = 1'b1;
            KIND_SET:     ok = set_hit;
            KIND_NOT_SET: ok = ~set_hit;
            default: begin
                if (i_subj.fold) ok = (lower_ascii(r_byte) == i_subj.sym_low);
                else             ok = (r_byte == i_subj.sym);
            end
        endcase
    end

    // Advance and closure chain
    assign is_star  = (r_kind == KIND_ANY_RUN);
    assign live     = i_cur & r_used;
    assign o_closed = i_adv | (live & is_star) | i_carry;
    assign o_adv    = live & ~is_star & ok;
    assign o_carry  = o_closed & r_used & is_star;

endmodule

// ===== src/gwm_checker.sv =====
// ----------------------------------------------------------------------------
// gwm_checker
// Port-level checks for the glob matcher, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gwm_checker import gwm_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input t_out_beat o_out_data,
    input logic      i_out_stall
);

    // A stalled result beat holds
    `GWM_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data), "result beat changed while stalled")

    // Overflow never reports a match
    `GWM_ASSERT(a_ovf_no_match, i_clk, i_rst_n, o_out_valid |-> !(o_out_data.overflow && o_out_data.matched), "match reported with overflow")

    // A result only follows an accepted beat
    `GWM_ASSERT(a_no_phantom, i_clk, i_rst_n, $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall), "result without an input beat")

    // Input stalls only while a result waits
    `GWM_ASSERT(a_stall_cause, i_clk, i_rst_n, o_in_stall |-> o_out_valid, "input stalled with empty output")

    // Reset empties the output
    `GWM_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !o_out_valid && !o_in_stall, "output not empty after reset")

endmodule

bind glob_wildcard_matcher gwm_checker u_gwm_checker (.*);
